>>> rtl/core/pac_pkg.sv
// Shared types, constants and helper functions of the PID controller core.
package pac_pkg;

	localparam int unsigned CFG_NUM = 8;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DIV_BITS = 52;
	localparam logic [19:0] MICROS_PER_S = 20'd1000000;
	localparam logic [19:0] HALF_MICRO = 20'd500000;
	localparam logic [95:0] STEP_LIMIT = {44'd0, MICROS_PER_S, 32'd0} - {76'd0, HALF_MICRO};
	localparam logic [32:0] STEP_CAP = {1'b1, 32'd0};
	localparam logic [66:0] ROUND_HALF = 67'd32768;

	typedef logic signed [31:0] word_t;

	typedef enum logic [2:0] {
		REG_TARGET,
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_INTEG_HIGH,
		REG_INTEG_LOW,
		REG_DRIVE_HIGH,
		REG_DRIVE_LOW
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CTL_IDLE,
		CTL_STEP,
		CTL_INTEG,
		CTL_MAC,
		CTL_ROUND,
		CTL_OUT
	} ctl_state_t;

	typedef enum logic [2:0] {
		STP_IDLE,
		STP_MUL,
		STP_RND,
		STP_DIV,
		STP_DONE
	} step_state_t;

	typedef enum logic [1:0] {
		MAC_IDLE,
		MAC_RUN,
		MAC_DONE
	} mac_state_t;

	typedef struct packed {
		logic [31:0] value;
		logic        hit;
	} clamp_t;

	function automatic word_t cfg_reset(cfg_reg_t r);
		word_t v;
		case (r)
			REG_TARGET:     v = 32'sd5898240;
			REG_GAIN_P:     v = 32'sd111411;
			REG_GAIN_I:     v = 32'sd52429;
			REG_GAIN_D:     v = 32'sd6554;
			REG_INTEG_HIGH: v = 32'sd6553600;
			REG_INTEG_LOW:  v = -32'sd6553600;
			REG_DRIVE_HIGH: v = 32'sd16711680;
			REG_DRIVE_LOW:  v = -32'sd16711680;
			default:        v = '0;
		endcase
		return v;
	endfunction

	// With crossed bounds, v below lo gives lo and any other v gives hi.
	function automatic clamp_t clamp_word(logic signed [50:0] v, word_t lo, word_t hi);
		clamp_t r;
		logic signed [50:0] lo_x;
		logic signed [50:0] hi_x;
		lo_x = $signed({{19{lo[31]}}, lo});
		hi_x = $signed({{19{hi[31]}}, hi});
		if (v < lo_x) begin
			r.value = lo;
			r.hit = 1'b1;
		end else if (v > hi_x) begin
			r.value = hi;
			r.hit = 1'b1;
		end else begin
			r.value = v[31:0];
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/pid_antiwindup_controller_core.sv
// Top level of the Q16.16 PID controller with clamped integral and clamped drive output.
// One request is taken at a time. It passes in order through the bit-serial multiply of
// error magnitude by elapsed microseconds, the rounding of the step, the restoring
// divide by one million, the integral clamp and the start of the multiply-accumulate,
// the three-lane bit-serial multiply-accumulate for the drive sum, the drive rounding
// and the drive clamp. The next request is stalled until the result has been loaded
// into the output register; that load waits while an earlier result is still stalled
// there. A finished result waits in the output register while the next request is
// accepted. Gains, setpoint and clamp bounds are to be written over the APB port only
// while the block is idle; the block itself does not enforce this.
module pid_antiwindup_controller_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  logic [63:0]                timestamp_us,
	input  logic signed [31:0]         angle,
	input  logic signed [31:0]         rate,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [31:0]         drive,
	output logic                       drive_saturated,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pac_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	pac_pkg::ctl_state_t state_q, state_d;
	pac_pkg::word_t cfg_q [pac_pkg::CFG_NUM];

	logic [63:0]        last_q;
	pac_pkg::word_t     acc_q;
	pac_pkg::word_t     err_q;
	pac_pkg::word_t     rate_q;
	logic               neg_q;
	logic signed [50:0] raw_q;
	logic [31:0]        drive_q;
	logic               sat_q;
	logic               result_valid_q;

	logic               sample_accept;
	logic               step_start;
	logic               step_done;
	logic [32:0]        step_total;
	logic               mac_start;
	logic               mac_done;
	logic signed [65:0] mac_sum;
	logic               load_out;

	logic [32:0]        err_diff;
	pac_pkg::word_t     err_sat;
	logic [31:0]        mag_in;
	logic [63:0]        elapsed_in;
	logic [34:0]        step_ext;
	logic [34:0]        integ_sum;
	pac_pkg::clamp_t    integ_c;
	logic [66:0]        round_sum;
	pac_pkg::clamp_t    drive_c;

	assign pready = 1'b1;
	assign prdata = cfg_q[paddr[4:2]];

	assign sample_stall = (state_q != pac_pkg::CTL_IDLE);
	assign sample_accept = sample_valid && !sample_stall;
	assign result_valid = result_valid_q;
	assign drive = $signed(drive_q);
	assign drive_saturated = sat_q;

	assign err_diff = {cfg_q[pac_pkg::REG_TARGET][31], cfg_q[pac_pkg::REG_TARGET]}
		- {angle[31], angle};
	always_comb begin
		if (err_diff[32] != err_diff[31]) begin
			err_sat = err_diff[32] ? $signed({1'b1, 31'd0}) : $signed({1'b0, {31{1'b1}}});
		end else begin
			err_sat = $signed(err_diff[31:0]);
		end
	end
	assign mag_in = err_sat[31] ? (~err_sat + 32'd1) : err_sat;
	assign elapsed_in = timestamp_us - last_q;

	assign step_ext = neg_q ? (35'd0 - {2'b0, step_total}) : {2'b0, step_total};
	assign integ_sum = {{3{acc_q[31]}}, acc_q} + step_ext;
	assign integ_c = pac_pkg::clamp_word($signed({{16{integ_sum[34]}}, integ_sum}),
		cfg_q[pac_pkg::REG_INTEG_LOW], cfg_q[pac_pkg::REG_INTEG_HIGH]);

	assign round_sum = {mac_sum[65], mac_sum} + pac_pkg::ROUND_HALF;
	assign drive_c = pac_pkg::clamp_word(raw_q,
		cfg_q[pac_pkg::REG_DRIVE_LOW], cfg_q[pac_pkg::REG_DRIVE_HIGH]);

	pac_step_unit u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (step_start),
		.mag     (mag_in),
		.elapsed (elapsed_in),
		.done    (step_done),
		.total   (step_total)
	);

	pac_mac_unit u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.err    (err_q),
		.integ  (integ_c.value),
		.rate   (rate_q),
		.gain_p (cfg_q[pac_pkg::REG_GAIN_P]),
		.gain_i (cfg_q[pac_pkg::REG_GAIN_I]),
		.gain_d (cfg_q[pac_pkg::REG_GAIN_D]),
		.done   (mac_done),
		.sum    (mac_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pac_pkg::CFG_NUM; i++) begin
				cfg_q[i] <= pac_pkg::cfg_reset(pac_pkg::cfg_reg_t'(i[2:0]));
			end
		end else if (psel && penable && pwrite) begin
			cfg_q[paddr[4:2]] <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pac_pkg::CTL_IDLE;
			last_q <= '0;
			acc_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sample_accept) last_q <= timestamp_us;
			if (state_q == pac_pkg::CTL_INTEG) acc_q <= integ_c.value;
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_accept) begin
			err_q <= err_sat;
			rate_q <= rate;
			neg_q <= err_sat[31];
		end
		if (state_q == pac_pkg::CTL_ROUND) raw_q <= $signed(round_sum[66:16]);
		if (load_out) begin
			drive_q <= drive_c.value;
			sat_q <= drive_c.hit;
		end
	end

	always_comb begin
		state_d = state_q;
		step_start = 1'b0;
		mac_start = 1'b0;
		load_out = 1'b0;
		case (state_q)
			pac_pkg::CTL_IDLE: begin
				if (sample_accept) begin
					step_start = 1'b1;
					state_d = pac_pkg::CTL_STEP;
				end
			end
			pac_pkg::CTL_STEP: begin
				if (step_done) state_d = pac_pkg::CTL_INTEG;
			end
			pac_pkg::CTL_INTEG: begin
				mac_start = 1'b1;
				state_d = pac_pkg::CTL_MAC;
			end
			pac_pkg::CTL_MAC: begin
				if (mac_done) state_d = pac_pkg::CTL_ROUND;
			end
			pac_pkg::CTL_ROUND: state_d = pac_pkg::CTL_OUT;
			pac_pkg::CTL_OUT: begin
				if (!result_valid_q || !result_stall) begin
					load_out = 1'b1;
					state_d = pac_pkg::CTL_IDLE;
				end
			end
			default: state_d = pac_pkg::CTL_IDLE;
		endcase
	end

endmodule

>>> rtl/core/pac_step_unit.sv
// Serial multiply by elapsed time and restoring divide by one million for the integral step.
module pac_step_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] mag,
	input  logic [63:0] elapsed,
	output logic        done,
	output logic [32:0] total
);

	localparam logic [5:0] MUL_LAST = 6'd31;
	localparam logic [5:0] DIV_LAST = 6'(pac_pkg::DIV_BITS - 1);

	pac_pkg::step_state_t state_q, state_d;
	logic [5:0]  cnt_q;
	logic [31:0] mag_sr_q;
	logic [63:0] elp_q;
	logic [63:0] ph_q;
	logic [31:0] pl_q;
	logic [pac_pkg::DIV_BITS-1:0] nsr_q;
	logic [19:0] rem_q;
	logic [31:0] quot_q;
	logic        ovf_q;

	logic [64:0] mul_x;
	logic [95:0] n_sum;
	logic [20:0] div_t;
	logic [20:0] div_sub;
	logic        div_ge;

	assign mul_x = {1'b0, ph_q} + (mag_sr_q[0] ? {1'b0, elp_q} : 65'd0);
	assign n_sum = {ph_q, pl_q} + {76'd0, pac_pkg::HALF_MICRO};
	assign div_t = {rem_q, nsr_q[pac_pkg::DIV_BITS-1]};
	assign div_sub = div_t - {1'b0, pac_pkg::MICROS_PER_S};
	assign div_ge = div_t >= {1'b0, pac_pkg::MICROS_PER_S};

	assign done = (state_q == pac_pkg::STP_DONE);
	assign total = ovf_q ? pac_pkg::STEP_CAP : {1'b0, quot_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pac_pkg::STP_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pac_pkg::STP_MUL || state_q == pac_pkg::STP_DIV) begin
				cnt_q <= cnt_q + 6'd1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pac_pkg::STP_IDLE: begin
				if (start) begin
					mag_sr_q <= mag;
					elp_q <= elapsed;
					ph_q <= '0;
					pl_q <= '0;
				end
			end
			pac_pkg::STP_MUL: begin
				ph_q <= mul_x[64:1];
				pl_q <= {mul_x[0], pl_q[31:1]};
				mag_sr_q <= {1'b0, mag_sr_q[31:1]};
			end
			pac_pkg::STP_RND: begin
				nsr_q <= n_sum[pac_pkg::DIV_BITS-1:0];
				ovf_q <= {ph_q, pl_q} >= pac_pkg::STEP_LIMIT;
				rem_q <= '0;
				quot_q <= '0;
			end
			pac_pkg::STP_DIV: begin
				rem_q <= div_ge ? div_sub[19:0] : div_t[19:0];
				quot_q <= {quot_q[30:0], div_ge};
				nsr_q <= {nsr_q[pac_pkg::DIV_BITS-2:0], 1'b0};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pac_pkg::STP_IDLE: begin
				if (start) state_d = pac_pkg::STP_MUL;
			end
			pac_pkg::STP_MUL: begin
				if (cnt_q == MUL_LAST) state_d = pac_pkg::STP_RND;
			end
			pac_pkg::STP_RND: state_d = pac_pkg::STP_DIV;
			pac_pkg::STP_DIV: begin
				if (cnt_q == DIV_LAST) state_d = pac_pkg::STP_DONE;
			end
			pac_pkg::STP_DONE: state_d = pac_pkg::STP_IDLE;
			default: state_d = pac_pkg::STP_IDLE;
		endcase
	end

endmodule

>>> rtl/core/pac_mac_unit.sv
// Three-lane bit-serial signed multiply-accumulate of the proportional, integral and rate terms.
module pac_mac_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  pac_pkg::word_t     err,
	input  pac_pkg::word_t     integ,
	input  pac_pkg::word_t     rate,
	input  pac_pkg::word_t     gain_p,
	input  pac_pkg::word_t     gain_i,
	input  pac_pkg::word_t     gain_d,
	output logic               done,
	output logic signed [65:0] sum
);

	localparam logic [4:0] RUN_LAST = 5'd31;

	pac_pkg::mac_state_t state_q, state_d;
	logic [4:0]  cnt_q;
	logic [31:0] ep_sr_q;
	logic [31:0] ei_sr_q;
	logic [31:0] ed_sr_q;
	logic [33:0] h_q;
	logic [31:0] l_q;

	logic [33:0] t_p;
	logic [33:0] t_i;
	logic [33:0] t_d;
	logic [33:0] t_sum;
	logic [34:0] t_ext;
	logic [34:0] h_ext;
	logic [34:0] acc_x;

	assign t_p = ep_sr_q[0] ? {{2{gain_p[31]}}, gain_p} : 34'd0;
	assign t_i = ei_sr_q[0] ? {{2{gain_i[31]}}, gain_i} : 34'd0;
	assign t_d = ed_sr_q[0] ? {{2{gain_d[31]}}, gain_d} : 34'd0;
	assign t_sum = t_p + t_i + t_d;
	assign t_ext = {t_sum[33], t_sum};
	assign h_ext = {h_q[33], h_q};
	// The top multiplier bit carries negative weight in two's complement.
	assign acc_x = (cnt_q == RUN_LAST) ? (h_ext - t_ext) : (h_ext + t_ext);

	assign done = (state_q == pac_pkg::MAC_DONE);
	assign sum = $signed({h_q, l_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pac_pkg::MAC_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pac_pkg::MAC_RUN) begin
				cnt_q <= cnt_q + 5'd1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pac_pkg::MAC_IDLE: begin
				if (start) begin
					ep_sr_q <= err;
					ei_sr_q <= integ;
					ed_sr_q <= rate;
					h_q <= '0;
					l_q <= '0;
				end
			end
			pac_pkg::MAC_RUN: begin
				h_q <= acc_x[34:1];
				l_q <= {acc_x[0], l_q[31:1]};
				ep_sr_q <= {1'b0, ep_sr_q[31:1]};
				ei_sr_q <= {1'b0, ei_sr_q[31:1]};
				ed_sr_q <= {1'b0, ed_sr_q[31:1]};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pac_pkg::MAC_IDLE: begin
				if (start) state_d = pac_pkg::MAC_RUN;
			end
			pac_pkg::MAC_RUN: begin
				if (cnt_q == RUN_LAST) state_d = pac_pkg::MAC_DONE;
			end
			pac_pkg::MAC_DONE: state_d = pac_pkg::MAC_IDLE;
			default: state_d = pac_pkg::MAC_IDLE;
		endcase
	end

endmodule

>>> rtl/core/pac_checker.sv
// Port-level assertions for the PID controller core and their binding to the top level.
module pac_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        sample_valid,
	input logic        sample_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [31:0] drive,
	input logic        drive_saturated
);

	// An accepted request makes the block stall further requests.
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("request accepted but the next cycle is not stalled");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> !$rose(result_valid))
		else $error("result appeared right after its request");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(drive)
			&& $stable(drive_saturated))
		else $error("stalled result changed or dropped");

	a_reset_clears: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result valid right after reset");

endmodule

bind pid_antiwindup_controller_core pac_checker u_pac_checker (.*);

>>> dv/tb_pid_antiwindup_controller_core.sv
// Self-checking testbench of the Q16.16 PID controller core with integral and drive clamps.
`timescale 1ns / 100ps

module tb_pid_antiwindup_controller_core;

	localparam pac_pkg::word_t ANGLE_90 = 32'sd5898240;
	localparam pac_pkg::word_t ANGLE_180 = 32'sd11796480;
	localparam pac_pkg::word_t WORD_MAX = 32'sh7fff_ffff;
	localparam pac_pkg::word_t WORD_MIN = 32'sh8000_0000;

	typedef struct packed {
		pac_pkg::word_t drive;
		logic           sat;
	} drive_out_t;

	class drive_predictor;
		localparam logic [63:0] US_PER_S = 64'd1000000;
		localparam logic [63:0] STEP_MAX = 64'h2_0000_0000;

		pac_pkg::word_t regs [pac_pkg::CFG_NUM];
		pac_pkg::word_t integral;
		logic [63:0] last_us;
		drive_out_t expected_drives [$];
		int unsigned mismatches;

		function void restart();
			regs[pac_pkg::REG_TARGET] = ANGLE_90;
			regs[pac_pkg::REG_GAIN_P] = 32'sd111411;
			regs[pac_pkg::REG_GAIN_I] = 32'sd52429;
			regs[pac_pkg::REG_GAIN_D] = 32'sd6554;
			regs[pac_pkg::REG_INTEG_HIGH] = 32'sd6553600;
			regs[pac_pkg::REG_INTEG_LOW] = -32'sd6553600;
			regs[pac_pkg::REG_DRIVE_HIGH] = 32'sd16711680;
			regs[pac_pkg::REG_DRIVE_LOW] = -32'sd16711680;
			integral = '0;
			last_us = '0;
			mismatches = 0;
		endfunction

		function void set_reg(pac_pkg::cfg_reg_t r, pac_pkg::word_t v);
			regs[r] = v;
		endfunction

		function int pending();
			return expected_drives.size();
		endfunction

		function void note_sample(logic [63:0] now, pac_pkg::word_t ang, pac_pkg::word_t spin);
			logic [63:0] elapsed;
			logic [63:0] mag;
			logic [63:0] whole_s;
			logic [63:0] frac_us;
			logic [63:0] step_mag;
			longint err;
			longint step;
			longint acc;
			logic signed [67:0] sum;
			logic signed [67:0] scaled;
			drive_out_t res;
			elapsed = now - last_us;
			last_us = now;
			err = longint'(regs[pac_pkg::REG_TARGET]) - longint'(ang);
			if (err > 64'sd2147483647) err = 64'sd2147483647;
			if (err < -64'sd2147483648) err = -64'sd2147483648;
			mag = (err < 0) ? 64'(-err) : 64'(err);
			whole_s = elapsed / US_PER_S;
			frac_us = elapsed % US_PER_S;
			if (mag != 0 && whole_s >= 64'h1_0000_0000) begin
				step_mag = STEP_MAX;
			end else begin
				step_mag = mag * whole_s + (mag * frac_us + US_PER_S / 2) / US_PER_S;
				if (step_mag > STEP_MAX) step_mag = STEP_MAX;
			end
			step = (err < 0) ? -longint'(step_mag) : longint'(step_mag);
			acc = longint'(integral) + step;
			if (acc < longint'(regs[pac_pkg::REG_INTEG_LOW])) begin
				integral = regs[pac_pkg::REG_INTEG_LOW];
			end else if (acc > longint'(regs[pac_pkg::REG_INTEG_HIGH])) begin
				integral = regs[pac_pkg::REG_INTEG_HIGH];
			end else begin
				integral = pac_pkg::word_t'(acc);
			end
			sum = longint'(regs[pac_pkg::REG_GAIN_P]) * err
				+ longint'(regs[pac_pkg::REG_GAIN_I]) * longint'(integral)
				+ longint'(regs[pac_pkg::REG_GAIN_D]) * longint'(spin);
			scaled = (sum + 68'sd32768) >>> 16;
			res.sat = 1'b1;
			if (scaled < regs[pac_pkg::REG_DRIVE_LOW]) begin
				res.drive = regs[pac_pkg::REG_DRIVE_LOW];
			end else if (scaled > regs[pac_pkg::REG_DRIVE_HIGH]) begin
				res.drive = regs[pac_pkg::REG_DRIVE_HIGH];
			end else begin
				res.drive = scaled[31:0];
				res.sat = 1'b0;
			end
			expected_drives.push_back(res);
		endfunction

		function void check_drive(pac_pkg::word_t d, logic s);
			drive_out_t want;
			if (expected_drives.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result: drive %0d saturated %b", $time, d, s);
				return;
			end
			want = expected_drives.pop_front();
			if (d !== want.drive) begin
				mismatches++;
				$display("%0t drive mismatch: expected %0d, got %0d", $time, want.drive, d);
			end
			if (s !== want.sat) begin
				mismatches++;
				$display("%0t drive_saturated mismatch: expected %b, got %b", $time, want.sat, s);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic [63:0] timestamp_us = '0;
	pac_pkg::word_t angle = '0;
	pac_pkg::word_t rate = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	pac_pkg::word_t drive;
	logic drive_saturated;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [pac_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	drive_predictor predictor;
	int unsigned send_gap_pct = 26;
	int unsigned stall_pct = 72;
	logic [63:0] clock_us;

	pid_antiwindup_controller_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.timestamp_us(timestamp_us),
		.angle(angle),
		.rate(rate),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.drive(drive),
		.drive_saturated(drive_saturated),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall) predictor.note_sample(timestamp_us, angle, rate);
			if (result_valid && !result_stall) predictor.check_drive(drive, drive_saturated);
		end
	end

	function automatic pac_pkg::word_t spread(int unsigned span);
		return pac_pkg::word_t'($urandom_range(0, 2 * span)) - pac_pkg::word_t'(span);
	endfunction

	task automatic send_sample(input logic [63:0] ts, input pac_pkg::word_t ang,
		input pac_pkg::word_t spin);
		while ($urandom_range(99) < send_gap_pct) begin
			sample_valid <= 1'b0;
			timestamp_us <= {$urandom, $urandom};
			angle <= $urandom;
			rate <= $urandom;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		timestamp_us <= ts;
		angle <= ang;
		rate <= spin;
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		do @(posedge clk); while (predictor.pending() != 0);
	endtask

	task automatic write_reg(input pac_pkg::cfg_reg_t r, input pac_pkg::word_t v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		predictor.set_reg(r, v);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_set(input int kind);
		pac_pkg::word_t v [pac_pkg::CFG_NUM];
		pac_pkg::cfg_reg_t r;
		v[pac_pkg::REG_TARGET] = spread(11796480);
		v[pac_pkg::REG_GAIN_P] = $urandom_range(0, 327680);
		v[pac_pkg::REG_GAIN_I] = $urandom_range(0, 131072);
		v[pac_pkg::REG_GAIN_D] = $urandom_range(0, 131072);
		v[pac_pkg::REG_INTEG_HIGH] = $urandom_range(65536, 13107200);
		v[pac_pkg::REG_INTEG_LOW] = -v[pac_pkg::REG_INTEG_HIGH];
		v[pac_pkg::REG_DRIVE_HIGH] = $urandom_range(65536, 16711680);
		v[pac_pkg::REG_DRIVE_LOW] = -v[pac_pkg::REG_DRIVE_HIGH];
		case (kind)
			1: begin
				v[pac_pkg::REG_TARGET] = WORD_MAX;
				v[pac_pkg::REG_GAIN_P] = WORD_MIN;
				v[pac_pkg::REG_GAIN_I] = WORD_MAX;
				v[pac_pkg::REG_GAIN_D] = WORD_MIN;
				v[pac_pkg::REG_INTEG_HIGH] = WORD_MAX;
				v[pac_pkg::REG_INTEG_LOW] = WORD_MIN;
				v[pac_pkg::REG_DRIVE_HIGH] = WORD_MAX;
				v[pac_pkg::REG_DRIVE_LOW] = WORD_MIN;
			end
			2: begin
				v[pac_pkg::REG_TARGET] = WORD_MIN;
				v[pac_pkg::REG_GAIN_P] = WORD_MAX;
				v[pac_pkg::REG_GAIN_I] = WORD_MIN;
				v[pac_pkg::REG_GAIN_D] = WORD_MAX;
				v[pac_pkg::REG_INTEG_HIGH] = '0;
				v[pac_pkg::REG_INTEG_LOW] = '0;
				v[pac_pkg::REG_DRIVE_HIGH] = '0;
				v[pac_pkg::REG_DRIVE_LOW] = '0;
			end
			3: begin
				// Low bounds above high bounds.
				v[pac_pkg::REG_INTEG_LOW] = $urandom_range(1, 6553600);
				v[pac_pkg::REG_INTEG_HIGH] = -pac_pkg::word_t'($urandom_range(0, 6553600));
				v[pac_pkg::REG_DRIVE_LOW] = $urandom_range(1, 16711680);
				v[pac_pkg::REG_DRIVE_HIGH] = -pac_pkg::word_t'($urandom_range(0, 16711680));
			end
			4: begin
				foreach (v[i]) v[i] = $urandom;
			end
			5: begin
				v[pac_pkg::REG_GAIN_P] = -v[pac_pkg::REG_GAIN_P];
				v[pac_pkg::REG_GAIN_I] = -v[pac_pkg::REG_GAIN_I];
				v[pac_pkg::REG_GAIN_D] = -v[pac_pkg::REG_GAIN_D];
				v[pac_pkg::REG_INTEG_HIGH] = $urandom_range(0, 65536);
				v[pac_pkg::REG_INTEG_LOW] = -v[pac_pkg::REG_INTEG_HIGH];
				v[pac_pkg::REG_DRIVE_HIGH] = $urandom_range(0, 655360);
				v[pac_pkg::REG_DRIVE_LOW] = -v[pac_pkg::REG_DRIVE_HIGH];
			end
			default: ;
		endcase
		r = r.first();
		do begin
			write_reg(r, v[r]);
			r = r.next();
		end while (r != r.first());
	endtask

	task automatic random_sample();
		pac_pkg::word_t ang;
		pac_pkg::word_t spin;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 80) clock_us = clock_us + $urandom_range(100, 20000);
		else if (pick < 90) clock_us = clock_us + 64'($urandom) * $urandom_range(1, 4000);
		else if (pick < 95) clock_us = clock_us - $urandom_range(1, 2000000);
		else clock_us = {$urandom, $urandom};
		if ($urandom_range(99) < 75) ang = predictor.regs[pac_pkg::REG_TARGET] + spread(1966080);
		else ang = $urandom;
		if ($urandom_range(99) < 60) spin = spread(6553600);
		else spin = $urandom;
		send_sample(clock_us, ang, spin);
	endtask

	initial begin
		#10_000_000;
		$display("tb_pid_antiwindup_controller_core NOT OK");
		$finish;
	end

	initial begin
		predictor = new;
		predictor.restart();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks under the reset configuration.
		send_sample(64'd1000, 32'sd0, 32'sd0);
		send_sample(64'd2000, ANGLE_90, 32'sd0);
		send_sample(64'd502000, ANGLE_90 - 32'sd1, 32'sd0);
		send_sample(64'd502001, WORD_MIN, WORD_MAX);
		send_sample(64'd502002, WORD_MAX, WORD_MIN);
		send_sample(64'd502002, 32'sd0, 32'sd0);
		send_sample(64'd1500, 32'sd0, 32'sd0);
		send_sample(64'hFFFF_FFFF_FFFF_FFFF, 32'sd0, 32'sd0);
		send_sample(64'd5, ANGLE_90, 32'sd0);
		clock_us = 64'h8000_0000_0000_0000;
		send_sample(clock_us, -32'sd1, -32'sd1);
		for (int k = 0; k < 7; k++) begin
			clock_us = clock_us + 64'd1000000;
			send_sample(clock_us, (k < 3) ? 32'sd0 : ANGLE_180, 32'sd0);
		end

		for (int batch = 0; batch < 14; batch++) begin
			if (batch == 5) begin
				send_gap_pct = 72;
				stall_pct = 26;
			end
			if (batch == 10) begin
				send_gap_pct = 0;
				stall_pct = 0;
			end
			wait_drained();
			program_set(batch % 6);
			for (int n = 0; n < 100; n++) random_sample();
		end
		wait_drained();
		repeat (200) @(posedge clk);

		if (predictor.mismatches == 0 && predictor.pending() == 0) begin
			$display("tb_pid_antiwindup_controller_core OK");
		end else begin
			$display("tb_pid_antiwindup_controller_core NOT OK");
		end
		$finish;
	end

endmodule
